@@ src/bcd_tuned_dds_word_defines.svh @@
// ----------------------------------------------------------------------------
// bcd tuned dds word assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BCD_TUNED_DDS_WORD_DEFINES_SVH
`define BCD_TUNED_DDS_WORD_DEFINES_SVH

// same-cycle implication
`define BCDTDW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcd tuned dds word check failed");

// next-cycle implication
`define BCDTDW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcd tuned dds word check failed");

`endif

@@ src/bcdtdw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdtdw_pkg
// types and constants of the decimal tuned dds frequency word block
// ----------------------------------------------------------------------------
package bcdtdw_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = 3;
  localparam int SEL_W      = 2;
  localparam int WORD_W     = 32;
  localparam int BCD_OUT_W  = 28;

  typedef logic [DIGIT_W-1:0] digit_t;

  localparam digit_t DIGIT_MAX = 4'd9;
  localparam digit_t DIGIT_MIN = 4'd0;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_mode_e;

  typedef struct packed {
    step_mode_e           mode;
    logic [IDX_W-1:0]     digit_index;
  } step_req_t;

  // weight of one unit of each decade, 10 MHz first
  localparam logic [WORD_W-1:0] DECADE_WORD [MAX_DIGITS] = '{
    32'h1999_999A, 32'h028F_5C29, 32'h0041_8937, 32'h0006_8DB9, 32'h0000_A7C6,
    32'h0000_10C7, 32'h0000_01AD, 32'h0000_002B, 32'h0000_0004, 32'h0000_0000
  };

  // 10.116 MHz
  localparam digit_t RESET_DIGITS [MAX_DIGITS] = '{
    4'd1, 4'd0, 4'd1, 4'd1, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  localparam logic [WORD_W-1:0] IF_WORD        = 32'h04B7_F5A5;
  localparam logic [WORD_W-1:0] TX_OFFSET_WORD = 32'h0000_8638;

  localparam int SEL_IF_BIT = 0;
  localparam int SEL_TX_BIT = 1;

endpackage

@@ src/bcdtdw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdtdw channel interfaces
// step request, result and sideband configuration channels, valid/ready
// ----------------------------------------------------------------------------
interface bcdtdw_in_if import bcdtdw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [IDX_W-1:0] digit_index;
  logic [SEL_W-1:0] offset_select;

  modport source (output valid, mode, digit_index, offset_select, input ready);
  modport sink   (input valid, mode, digit_index, offset_select, output ready);
endinterface

interface bcdtdw_out_if import bcdtdw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    tuning_word;
  logic [BCD_OUT_W-1:0] frequency_bcd;

  modport source (output valid, tuning_word, frequency_bcd, input ready);
  modport sink   (input valid, tuning_word, frequency_bcd, output ready);
endinterface

interface bcdtdw_cfg_if ();
  logic valid;
  logic ready;
  logic upper_sideband;

  modport source (output valid, upper_sideband, input ready);
  modport sink   (input valid, upper_sideband, output ready);
endinterface

@@ src/bcd_tuned_dds_word.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_tuned_dds_word
// decimal tuned frequency register with dds tuning word output
// ----------------------------------------------------------------------------
// usage:
//   in_item  : step request (mode, digit_index, offset_select). each accepted
//              item yields one result; an up/down one steps the stored decimal frequency.
//   out_item : tuning_word and frequency_bcd after the step.
//   cfg_wr   : upper_sideband, always ready; write it only while idle.
// pipeline: the result passes through three register stages in order (step
//   and snapshot, decade-weighted sum, offset add/subtract). throughput: one
//   item per cycle while out_item is taken, set by the digit step loop, which
//   closes through the digit register.
// reset: frequency returns to 10.116 MHz, upper sideband is selected and
//   all stages are emptied.
// stall: while out_item is not taken it holds its item and earlier stages fill
//   behind it; in_item.ready drops only once all three stages are full.
// ----------------------------------------------------------------------------
`include "bcd_tuned_dds_word_defines.svh"

module bcd_tuned_dds_word import bcdtdw_pkg::*; #(
  parameter int NUM_DIGITS = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  bcdtdw_in_if.sink    in_item,
  bcdtdw_out_if.source out_item,
  bcdtdw_cfg_if.sink   cfg_wr
);

  localparam int BCD_ALL_W = MAX_DIGITS * DIGIT_W;

  // configuration
  logic sideband_q;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sideband_q <= 1'b1;
    end else if (cfg_wr.valid) begin
      sideband_q <= cfg_wr.upper_sideband;
    end
  end

  // pipeline handshake
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready;
  logic in_fire;

  assign s3_ready      = !out_valid_q || out_item.ready;
  assign s2_ready      = !s2_valid_q || s3_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign in_item.ready = s1_ready;
  assign in_fire       = in_item.valid && s1_ready;

  // frequency state and step
  digit_t    digits_q [NUM_DIGITS];
  digit_t    digits_d [NUM_DIGITS];
  step_req_t step_req;

  assign step_req.mode        = step_mode_e'(in_item.mode);
  assign step_req.digit_index = in_item.digit_index;

  bcdtdw_step #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_step (
    .req_i    (step_req),
    .digits_i (digits_q),
    .digits_o (digits_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits_q[i] <= RESET_DIGITS[i];
      end
    end else if (in_fire) begin
      digits_q <= digits_d;
    end
  end

  // stage 1: snapshot of the stepped digits
  digit_t           s1_digits_q [NUM_DIGITS];
  logic [SEL_W-1:0] s1_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_item.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_digits_q <= digits_d;
      s1_sel_q    <= in_item.offset_select;
    end
  end

  // stage 2: decade-weighted sum and packed bcd
  logic [WORD_W-1:0]    sum_d, s2_sum_q;
  logic [BCD_ALL_W-1:0] bcd_all;
  logic [BCD_OUT_W-1:0] s2_bcd_q;
  logic [SEL_W-1:0]     s2_sel_q;

  always_comb begin
    sum_d   = '0;
    bcd_all = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      sum_d = sum_d + WORD_W'(WORD_W'(s1_digits_q[i]) * DECADE_WORD[i]);
      bcd_all[(NUM_DIGITS - 1 - i) * DIGIT_W +: DIGIT_W] = s1_digits_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_sum_q <= sum_d;
      s2_bcd_q <= bcd_all[BCD_OUT_W-1:0];
      s2_sel_q <= s1_sel_q;
    end
  end

  // stage 3: offsets, added on upper sideband, subtracted on lower
  logic [WORD_W-1:0]    offset;
  logic [WORD_W-1:0]    word_d, word_q;
  logic [BCD_OUT_W-1:0] bcd_q;

  assign offset = (s2_sel_q[SEL_IF_BIT] ? IF_WORD : '0)
                + (s2_sel_q[SEL_TX_BIT] ? TX_OFFSET_WORD : '0);
  assign word_d = sideband_q ? (s2_sum_q + offset) : (s2_sum_q - offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      word_q <= word_d;
      bcd_q  <= s2_bcd_q;
    end
  end

  assign out_item.valid         = out_valid_q;
  assign out_item.tuning_word   = word_q;
  assign out_item.frequency_bcd = bcd_q;

  // checks
  logic [NUM_DIGITS*DIGIT_W-1:0] digits_flat;
  logic                          no_step;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digits_flat[i * DIGIT_W +: DIGIT_W] = digits_q[i];
    end
  end

  assign no_step = (in_item.mode != STEP_UP && in_item.mode != STEP_DOWN)
                || (int'(in_item.digit_index) >= NUM_DIGITS);

  `BCDTDW_ASSERT_NEXT(a_no_step_holds_freq, in_fire && no_step, $stable(digits_flat))
  `BCDTDW_ASSERT_NEXT(a_idle_holds_freq, !in_fire, $stable(digits_flat))
  `BCDTDW_ASSERT_NEXT(a_stalled_mid_stage_holds, s2_valid_q && !s3_ready, s2_valid_q)
  `BCDTDW_ASSERT_NOW(a_full_pipe_blocks_input, s1_valid_q && s2_valid_q && out_valid_q
                     && !out_item.ready, !in_item.ready)

endmodule

@@ src/bcdtdw_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdtdw_step
// one-unit decimal step at a chosen digit with carry/borrow toward digit 0
// ----------------------------------------------------------------------------
module bcdtdw_step import bcdtdw_pkg::*; #(
  parameter int NUM_DIGITS = 7
) (
  input  step_req_t req_i,
  input  digit_t    digits_i [NUM_DIGITS],
  output digit_t    digits_o [NUM_DIGITS]
);

  // ripple from the least significant digit up; carry out of digit 0 is dropped
  always_comb begin
    logic carry;
    logic hit;
    carry = 1'b0;
    hit   = 1'b0;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      hit         = carry || (int'(req_i.digit_index) == i);
      carry       = 1'b0;
      digits_o[i] = digits_i[i];
      if (hit) begin
        case (req_i.mode)
          STEP_UP: begin
            if (digits_i[i] == DIGIT_MAX) begin
              digits_o[i] = DIGIT_MIN;
              carry       = 1'b1;
            end else begin
              digits_o[i] = digits_i[i] + 4'd1;
            end
          end
          STEP_DOWN: begin
            if (digits_i[i] == DIGIT_MIN) begin
              digits_o[i] = DIGIT_MAX;
              carry       = 1'b1;
            end else begin
              digits_o[i] = digits_i[i] - 4'd1;
            end
          end
          default: begin
            digits_o[i] = digits_i[i];
          end
        endcase
      end
    end
  end

endmodule
